// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tanh_pkg.sv =====
// ----------------------------------------------------------------------------
// tanh_pkg
// Shared widths, defaults and transfer payload types for the tanh block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tanh_pkg;

  localparam int DATA_W            = 16;
  localparam int DEF_IN_FRAC_BITS  = 12;
  localparam int DEF_OUT_FRAC_BITS = 14;
  localparam int TAYLOR_TERMS      = 17;
  localparam int SQUARINGS         = 4;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_value;
    logic                     last_in;
  } tanh_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y_value;
    logic                     last_out;
  } tanh_out_t;

  typedef struct packed {
    logic neg;
    logic sat;
    logic last;
  } tanh_side_t;

endpackage

// ===== rtl/core/tanh_activation_fixed_top.sv =====
// ----------------------------------------------------------------------------
// tanh_activation_fixed_top
// Streaming fixed-point hyperbolic tangent, one element per clock unless the output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Takes one signed sample per cycle while the output is not stalled and
// returns tanh of it, rounded to nearest and saturated to plus or minus one,
// with the last flag carried alongside. Sustained throughput is one transfer
// per cycle on each side while results are taken. The pipeline depth is set
// by the exp(-2|x|) series, which spends three stages on each of its
// seventeen terms, the four squaring multipliers, and the restoring divider
// that retires one quotient bit per stage. A two-entry output buffer keeps
// input accepting while a result waits, until a second result fills the skid
// entry; then the whole pipeline freezes without loss.

`include "assert_macros.svh"

module tanh_activation_fixed_top #(
  parameter int IN_FRAC_BITS  = tanh_pkg::DEF_IN_FRAC_BITS,
  parameter int OUT_FRAC_BITS = tanh_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  tanh_pkg::tanh_in_t  sample,
  output logic                result_valid,
  input  logic                result_ready,
  output tanh_pkg::tanh_out_t result
);

  import tanh_pkg::*;

  localparam int TERMS   = TAYLOR_TERMS;
  localparam int E_W     = 32;
  localparam int Y_W     = 31;
  localparam int P_W     = 63;
  localparam int SUM_W   = 40;
  localparam int D_W     = 33;
  localparam int QW      = OUT_FRAC_BITS + 1;
  localparam int NW      = E_W + 1 + OUT_FRAC_BITS;
  localparam int Y_SHIFT = 28 - IN_FRAC_BITS;

  localparam logic [DATA_W+1:0] LARGE_LIM = (DATA_W + 2)'(8 << IN_FRAC_BITS);
  localparam logic [E_W-1:0]    Q31_ONE   = E_W'(64'd1 << 31);
  localparam logic [QW-1:0]     MAG_ONE   = {1'b1, {OUT_FRAC_BITS{1'b0}}};
  localparam logic [DATA_W-1:0] POS_MAX   = {1'b0, {(DATA_W-1){1'b1}}};

  logic en;
  logic arrive;
  logic skid_valid;
  tanh_out_t skid_data;
  tanh_out_t fin_data;

  assign en           = !skid_valid;
  assign sample_ready = en;

  // input stage
  logic [DATA_W:0] a_mag;
  logic [63:0]     y_wide;
  tanh_side_t      in_side;

  always_comb begin
    in_side.neg   = sample.x_value[DATA_W-1];
    in_side.last  = sample.last_in;
    a_mag         = in_side.neg ? (DATA_W + 1)'({1'b1, {DATA_W{1'b0}}} - {1'b0, sample.x_value})
                                : {1'b0, sample.x_value};
    in_side.sat   = {1'b0, a_mag} >= LARGE_LIM;
    y_wide        = 64'(a_mag) << Y_SHIFT;
  end

  logic           s0_valid;
  tanh_side_t     s0_side;
  logic [Y_W-1:0] s0_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side <= in_side;
      s0_y    <= y_wide[Y_W-1:0];
    end
  end

  // series terms: multiply, reciprocal estimate, correct and accumulate
  logic                    m_valid [TERMS];
  logic [P_W-1:0]          m_prod  [TERMS];
  logic signed [SUM_W-1:0] m_sum   [TERMS];
  logic [Y_W-1:0]          m_y     [TERMS];
  tanh_side_t              m_side  [TERMS];

  logic                    r_valid [TERMS];
  logic [Y_W-1:0]          r_v     [TERMS];
  logic [Y_W-1:0]          r_qe    [TERMS];
  logic signed [SUM_W-1:0] r_sum   [TERMS];
  logic [Y_W-1:0]          r_y     [TERMS];
  tanh_side_t              r_side  [TERMS];

  logic                    c_valid [TERMS];
  logic [Y_W-1:0]          c_q     [TERMS];
  logic signed [SUM_W-1:0] c_sum   [TERMS];
  logic [Y_W-1:0]          c_y     [TERMS];
  tanh_side_t              c_side  [TERMS];

  for (genvar j = 0; j < TERMS; j++) begin : g_term
    localparam int K = j + 1;
    localparam logic [D_W-1:0] RECIP = D_W'((64'd1 << 32) / K);
    localparam bit SUBTRACT = (K % 2) == 1;

    logic [E_W-1:0]          term_in;
    logic signed [SUM_W-1:0] sum_in;
    logic [Y_W-1:0]          y_in;
    tanh_side_t              side_in;
    logic                    valid_in;
    logic [63:0]             recip_prod;
    logic [35:0]             qk;
    logic [36:0]             rem;
    logic [Y_W-1:0]          q;
    logic signed [SUM_W-1:0] q_ext;

    if (j == 0) begin : g_first
      assign term_in  = Q31_ONE;
      assign sum_in   = $signed({{(SUM_W-E_W){1'b0}}, Q31_ONE});
      assign y_in     = s0_y;
      assign side_in  = s0_side;
      assign valid_in = s0_valid;
    end else begin : g_rest
      assign term_in  = {1'b0, c_q[j-1]};
      assign sum_in   = c_sum[j-1];
      assign y_in     = c_y[j-1];
      assign side_in  = c_side[j-1];
      assign valid_in = c_valid[j-1];
    end

    assign recip_prod = 64'(m_prod[j][61:31]) * 64'(RECIP);
    assign qk         = 36'(r_qe[j]) * 36'(K);
    assign rem        = 37'(r_v[j]) - 37'(qk);
    assign q          = (rem >= 37'(K)) ? r_qe[j] + Y_W'(1) : r_qe[j];
    assign q_ext      = $signed({{(SUM_W-Y_W){1'b0}}, q});

    always_ff @(posedge clk) begin
      if (rst) begin
        m_valid[j] <= 1'b0;
        r_valid[j] <= 1'b0;
        c_valid[j] <= 1'b0;
      end else if (en) begin
        m_valid[j] <= valid_in;
        r_valid[j] <= m_valid[j];
        c_valid[j] <= r_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_prod[j] <= P_W'(term_in) * P_W'(y_in);
        m_sum[j]  <= sum_in;
        m_y[j]    <= y_in;
        m_side[j] <= side_in;

        r_v[j]    <= m_prod[j][61:31];
        r_qe[j]   <= recip_prod[62:32];
        r_sum[j]  <= m_sum[j];
        r_y[j]    <= m_y[j];
        r_side[j] <= m_side[j];

        c_q[j]    <= q;
        c_sum[j]  <= SUBTRACT ? r_sum[j] - q_ext : r_sum[j] + q_ext;
        c_y[j]    <= r_y[j];
        c_side[j] <= r_side[j];
      end
    end
  end

  // clamp series to [0, 1]
  logic                    cl_valid;
  logic [E_W-1:0]          cl_e;
  tanh_side_t              cl_side;
  logic signed [SUM_W-1:0] sum_last;
  logic [E_W-1:0]          e_clamped;

  assign sum_last  = c_sum[TERMS-1];
  assign e_clamped = (sum_last < 0) ? '0 :
                     (sum_last > $signed({{(SUM_W-E_W){1'b0}}, Q31_ONE})) ? Q31_ONE :
                     sum_last[E_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_valid <= 1'b0;
    end else if (en) begin
      cl_valid <= c_valid[TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cl_e    <= e_clamped;
      cl_side <= c_side[TERMS-1];
    end
  end

  // raise to the 16th power
  logic           sq_valid [SQUARINGS];
  logic [P_W-1:0] sq_prod  [SQUARINGS];
  tanh_side_t     sq_side  [SQUARINGS];

  for (genvar s = 0; s < SQUARINGS; s++) begin : g_square
    logic [E_W-1:0] e_in;
    tanh_side_t     side_in;
    logic           valid_in;

    if (s == 0) begin : g_first
      assign e_in     = cl_e;
      assign side_in  = cl_side;
      assign valid_in = cl_valid;
    end else begin : g_rest
      assign e_in     = sq_prod[s-1][62:31];
      assign side_in  = sq_side[s-1];
      assign valid_in = sq_valid[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[s] <= 1'b0;
      end else if (en) begin
        sq_valid[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_prod[s] <= P_W'(e_in) * P_W'(e_in);
        sq_side[s] <= side_in;
      end
    end
  end

  // divider setup: (num << OUT_FRAC_BITS + den / 2) / den
  logic [E_W-1:0] e_fin;
  logic [E_W-1:0] num;
  logic [D_W-1:0] den;
  logic [NW-1:0]  dividend;

  assign e_fin    = sq_prod[SQUARINGS-1][62:31];
  assign num      = Q31_ONE - e_fin;
  assign den      = {1'b0, Q31_ONE} + {1'b0, e_fin};
  assign dividend = NW'({num, {OUT_FRAC_BITS{1'b0}}}) + NW'(den >> 1);

  logic           pr_valid;
  logic [D_W-1:0] pr_rem;
  logic [QW-1:0]  pr_low;
  logic [D_W-1:0] pr_den;
  tanh_side_t     pr_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (en) begin
      pr_valid <= sq_valid[SQUARINGS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_rem  <= {1'b0, dividend[NW-1:QW]};
      pr_low  <= dividend[QW-1:0];
      pr_den  <= den;
      pr_side <= sq_side[SQUARINGS-1];
    end
  end

  // restoring divider, one quotient bit per stage
  logic           dv_valid [QW];
  logic [D_W-1:0] dv_rem   [QW];
  logic [QW-1:0]  dv_low   [QW];
  logic [QW-1:0]  dv_q     [QW];
  logic [D_W-1:0] dv_den   [QW];
  tanh_side_t     dv_side  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [D_W-1:0] rem_in;
    logic [QW-1:0]  low_in;
    logic [QW-1:0]  q_in;
    logic [D_W-1:0] den_in;
    tanh_side_t     side_in;
    logic           valid_in;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           fits;

    if (i == 0) begin : g_first
      assign rem_in   = pr_rem;
      assign low_in   = pr_low;
      assign q_in     = '0;
      assign den_in   = pr_den;
      assign side_in  = pr_side;
      assign valid_in = pr_valid;
    end else begin : g_rest
      assign rem_in   = dv_rem[i-1];
      assign low_in   = dv_low[i-1];
      assign q_in     = dv_q[i-1];
      assign den_in   = dv_den[i-1];
      assign side_in  = dv_side[i-1];
      assign valid_in = dv_valid[i-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign fits  = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[i] <= 1'b0;
      end else if (en) begin
        dv_valid[i] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[i]  <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
        dv_low[i]  <= {low_in[QW-2:0], 1'b0};
        dv_q[i]    <= {q_in[QW-2:0], fits};
        dv_den[i]  <= den_in;
        dv_side[i] <= side_in;
      end
    end
  end

  // saturate, apply sign
  logic [QW-1:0]     dq;
  logic [QW-1:0]     mag;
  logic [DATA_W-1:0] mag_w;
  tanh_side_t        fin_side;

  always_comb begin
    fin_side = dv_side[QW-1];
    dq       = dv_q[QW-1];
    mag      = (fin_side.sat || dq > MAG_ONE) ? MAG_ONE : dq;
    mag_w    = DATA_W'(mag);
    if (fin_side.neg) begin
      fin_data.y_value = $signed(DATA_W'(0) - mag_w);
    end else begin
      fin_data.y_value = $signed((mag_w > POS_MAX) ? POS_MAX : mag_w);
    end
    fin_data.last_out = fin_side.last;
  end

  assign arrive = en && dv_valid[QW-1];

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (arrive) begin
      if (!result_valid || result_ready) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_ready) begin
        result <= skid_data;
      end
    end else if (arrive) begin
      if (!result_valid || result_ready) begin
        result <= fin_data;
      end else begin
        skid_data <= fin_data;
      end
    end
  end

  `ASSERT_IMP(a_skid_needs_out, skid_valid, result_valid, "skid full with output empty")
  `ASSERT_NEXT(a_stall_fills_skid, arrive && result_valid && !result_ready,
               skid_valid, "stalled result not captured in skid")
  `ASSERT_NEXT(a_skid_holds, skid_valid && !result_ready,
               skid_valid && !sample_ready && $stable(result),
               "skid or output changed during stall")

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tanh_activation_fixed_top: a queued driver and a
// monitor check every transfer against a bit-exact tanh predictor, under
// random idling on both sides, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tanh_pkg::*;

  localparam int IN_FRAC   = DEF_IN_FRAC_BITS;
  localparam int OUT_FRAC  = DEF_OUT_FRAC_BITS;
  localparam int N_RANDOM  = 2000;
  localparam int PAUSE_AT  = 700;
  localparam int STALL_AT  = 1200;
  localparam int STALL_LEN = 400;
  localparam int CALM_LO   = 1500;
  localparam int CALM_HI   = 2500;
  localparam longint unsigned Q31 = 64'd1 << 31;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      sample_valid = 1'b0;
  logic      sample_ready;
  tanh_in_t  sample = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  tanh_out_t result;

  tanh_in_t  pending_in[$];
  tanh_out_t predicted_out[int];
  int        n_accepted = 0;
  int        n_checked = 0;
  int        n_total = 0;
  int        errors = 0;
  int        cyc = 0;
  int        stall_left = 0;
  bit        stall_done = 1'b0;
  int        acc_now;
  logic      calm;

  tanh_activation_fixed_top #(
    .IN_FRAC_BITS (IN_FRAC),
    .OUT_FRAC_BITS(OUT_FRAC)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // tanh via (1 - e) / (1 + e), e = exp(-2a/16)^16 from a truncated series
  function automatic tanh_out_t predict_tanh(tanh_in_t s);
    logic [15:0]     raw;
    logic            neg;
    logic [16:0]     a;
    longint unsigned y, term, e, num, den, mag;
    longint          sum;
    tanh_out_t       r;
    raw = s.x_value;
    neg = raw[15];
    a = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    if (a >= (17'd8 << IN_FRAC)) begin
      mag = 64'd1 << OUT_FRAC;
    end else begin
      y = 64'(a) << (28 - IN_FRAC);
      term = Q31;
      sum = longint'(Q31);
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        term = ((term * y) >> 31) / 64'(k);
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      e = longint'(sum);
      if (e > Q31) e = Q31;
      for (int k = 0; k < SQUARINGS; k++) e = (e * e) >> 31;
      num = Q31 - e;
      den = Q31 + e;
      mag = ((num << OUT_FRAC) + (den >> 1)) / den;
      if (mag > (64'd1 << OUT_FRAC)) mag = 64'd1 << OUT_FRAC;
    end
    if (neg) begin
      r.y_value = 16'((64'h10000 - mag) & 64'hFFFF);
    end else begin
      if (mag > 64'h7FFF) mag = 64'h7FFF;
      r.y_value = 16'(mag);
    end
    r.last_out = s.last_in;
    return r;
  endfunction

  function automatic logic [15:0] random_x();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: begin
        return 16'($urandom);
      end
      4, 5, 6: begin
        return 16'($signed($urandom_range(16383)) - 8192);
      end
      7: begin
        return 16'(32768 - 512 + $urandom_range(511));
      end
      8: begin
        return 16'(28672 - 256 + $urandom_range(511)) ^ ($urandom_range(1) ? 16'hFFFF : 16'h0);
      end
      default: begin
        case ($urandom_range(4))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'hFFFF;
          3: return 16'h7FFF;
          default: return 16'h8000;
        endcase
      end
    endcase
  endfunction

  task automatic queue_sample(logic [15:0] x, logic last);
    tanh_in_t s;
    s.x_value = x;
    s.last_in = last;
    pending_in.push_back(s);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  assign calm = (cyc >= CALM_LO) && (cyc < CALM_HI);

  // driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      acc_now = n_accepted;
      if (sample_valid && sample_ready) begin
        predicted_out[n_accepted] = predict_tanh(sample);
        acc_now = n_accepted + 1;
        n_accepted <= acc_now;
      end
      if (!sample_valid || sample_ready) begin
        if (pending_in.size() != 0 &&
            !(acc_now == PAUSE_AT && n_checked != acc_now) &&
            (calm || $urandom_range(99) >= 30)) begin
          sample <= pending_in.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (n_checked >= n_accepted) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual y=%0d last=%0b",
                   $time, result.y_value, result.last_out);
        end else begin
          if (result.y_value !== predicted_out[n_checked].y_value) begin
            errors++;
            $display("%0t: item %0d y_value expected %0d actual %0d", $time, n_checked,
                     predicted_out[n_checked].y_value, result.y_value);
          end
          if (result.last_out !== predicted_out[n_checked].last_out) begin
            errors++;
            $display("%0t: item %0d last_out expected %0b actual %0b", $time, n_checked,
                     predicted_out[n_checked].last_out, result.last_out);
          end
          predicted_out.delete(n_checked);
          n_checked <= n_checked + 1;
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 1'b0;
      end else if (!stall_done && n_checked >= STALL_AT) begin
        stall_done <= 1'b1;
        stall_left <= STALL_LEN;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin
    int guard;
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'h0001, 1'b0);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'h7FFF, 1'b0);
    queue_sample(16'h8000, 1'b1);
    queue_sample(16'h8001, 1'b0);
    queue_sample(16'h1000, 1'b0);
    queue_sample(16'hF000, 1'b0);
    queue_sample(16'h0800, 1'b1);
    queue_sample(16'hF800, 1'b0);
    queue_sample(16'h2000, 1'b0);
    queue_sample(16'h4000, 1'b0);
    queue_sample(16'hC000, 1'b1);
    queue_sample(16'h7000, 1'b0);
    queue_sample(16'h9000, 1'b0);
    queue_sample(16'h6000, 1'b0);
    queue_sample(16'h0064, 1'b1);
    queue_sample(16'hFF9C, 1'b0);
    queue_sample(16'h5555, 1'b0);
    queue_sample(16'hAAAA, 1'b1);
    for (int i = 0; i < N_RANDOM; i++) begin
      queue_sample(random_x(), ($urandom_range(7) == 0));
    end
    n_total = pending_in.size();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (n_accepted < n_total) @(posedge clk);
    guard = 0;
    while (n_checked < n_accepted && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (n_checked != n_accepted) begin
      $display("%0t: %0d expected transfers never arrived", $time, n_accepted - n_checked);
    end
    $display("tb: %0d samples sent, %0d results checked, %0d mismatches", n_accepted,
             n_checked, errors);
    $display("tb: covered extremes, random idling, a full-pipeline stall and a drain pause");
    if (errors == 0 && n_checked == n_accepted) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: timeout at %0t", $time);
    $display("tb: done, errors");
    $finish;
  end

endmodule
